// ===== src/assert_macros.svh =====
// Assertion macros shared by the converter's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define QTE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("converter check failed");

// When the trigger holds, the consequence must hold in the following cycle.
`define QTE_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("converter sequence check failed");

`endif

// ===== src/qte_pkg.sv =====
package qte_pkg;

   // Number of rotation stages in each angle unit (8 to 24).
   localparam int CORDIC_STAGES = 16;

   // Field and datapath widths.
   localparam int IN_W   = 16;
   localparam int PROD_W = 32;
   localparam int VEC_W  = 36;
   localparam int ANG_W  = 32;
   localparam int S_W    = 29;
   localparam int FULL_W = 34;
   localparam int ATAN_W = 28;

   // Square root: one result bit per stage over a 58-bit radicand.
   localparam int ROOT_STEPS = 29;
   localparam int RAD_W      = 58;

   // Pipeline levels of the back end, counted from the queue read register.
   localparam int SQRT_LEVEL = 2 + ROOT_STEPS;
   localparam int CORDIC_LAT = CORDIC_STAGES + 1;
   localparam int OUT_LEVEL  = SQRT_LEVEL + CORDIC_LAT;
   localparam int ANG_DELAY  = SQRT_LEVEL;

   // Queue between front and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Fixed-point constants: products in Q28, angles in degrees times 2^22.
   localparam logic signed [32:0] POLE_LIMIT = 33'sd134217459;
   localparam logic signed [VEC_W-1:0] Q28_ONE = VEC_W'(64'sd268435456);
   localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd754974720;
   localparam logic signed [FULL_W-1:0] ANG_90 = 34'sd377487360;

   // Output saturation limits in degrees times 64.
   localparam logic [15:0] BANK_LIM = 16'd5760;
   localparam logic [15:0] HEAD_LIM = 16'd11520;
   localparam logic [15:0] ATT_LIM  = 16'd23040;

   // Rotation angles atan(2^-i), degrees times 2^22.
   localparam logic [ATAN_W-1:0] ATAN_TABLE [24] = '{
      28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
      28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
      28'd938729,    28'd469366,    28'd234683,   28'd117342,
      28'd58671,     28'd29335,     28'd14668,    28'd7334,
      28'd3667,      28'd1833,      28'd917,      28'd458,
      28'd229,       28'd115,       28'd57,       28'd29
   };

   // Which formula set applies to a word.
   typedef enum logic [1:0] {
      CLS_GENERAL,
      CLS_NORTH,
      CLS_SOUTH
   } qte_class_type;

   // One classified word waiting for the back end.
   typedef struct packed {
      qte_class_type          cls;
      logic signed [VEC_W-1:0] att_y;
      logic signed [VEC_W-1:0] att_x;
      logic signed [VEC_W-1:0] hd_y;
      logic signed [VEC_W-1:0] hd_x;
      logic signed [S_W-1:0]   s;
   } qte_entry_type;

endpackage

// ===== src/qte_front.sv =====
`include "assert_macros.svh"

module qte_front import qte_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IN_W-1:0] req_quat_w,
   input  logic signed [IN_W-1:0] req_quat_x,
   input  logic signed [IN_W-1:0] req_quat_y,
   input  logic signed [IN_W-1:0] req_quat_z,
   output logic                   push_valid,
   input  logic                   push_ready,
   output qte_entry_type          push_entry
);

   logic                     f1_valid_ff;
   logic signed [PROD_W-1:0] p_xw_ff, p_yz_ff, p_zw_ff, p_yx_ff, p_yw_ff;
   logic signed [PROD_W-1:0] p_zx_ff, p_zz_ff, p_xx_ff, p_yy_ff;
   logic signed [IN_W-1:0]   w_ff, z_ff;

   logic signed [32:0]       test;
   logic signed [VEC_W-1:0]  an, ad, hn, hd, pole_y, pole_x;
   logic                     north, south;

   // The product stage moves whenever its word leaves or it is empty.
   assign req_ready  = !f1_valid_ff || push_ready;
   assign push_valid = f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         f1_valid_ff <= req_valid;
      end
   end

   // All nine products of the formulas, formed in parallel.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         p_xw_ff <= req_quat_x * req_quat_w;
         p_yz_ff <= req_quat_y * req_quat_z;
         p_zw_ff <= req_quat_z * req_quat_w;
         p_yx_ff <= req_quat_y * req_quat_x;
         p_yw_ff <= req_quat_y * req_quat_w;
         p_zx_ff <= req_quat_z * req_quat_x;
         p_zz_ff <= req_quat_z * req_quat_z;
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         w_ff    <= req_quat_w;
         z_ff    <= req_quat_z;
      end
   end

   // Sums, pole test and the vectors that the angle units will resolve.
   always_comb begin
      test   = 33'(p_xw_ff) - 33'(p_yz_ff);
      north  = test > POLE_LIMIT;
      south  = test < -POLE_LIMIT;
      an     = (VEC_W'(p_zw_ff) + VEC_W'(p_yx_ff)) <<< 1;
      ad     = Q28_ONE - ((VEC_W'(p_zz_ff) + VEC_W'(p_xx_ff)) <<< 1);
      hn     = (VEC_W'(p_yw_ff) + VEC_W'(p_zx_ff)) <<< 1;
      hd     = Q28_ONE - ((VEC_W'(p_yy_ff) + VEC_W'(p_xx_ff)) <<< 1);
      pole_y = {{(VEC_W-IN_W-14){z_ff[IN_W-1]}}, z_ff, 14'b0};
      pole_x = {{(VEC_W-IN_W-14){w_ff[IN_W-1]}}, w_ff, 14'b0};

      push_entry.hd_y = hn;
      push_entry.hd_x = hd;
      push_entry.s    = {test[S_W-2:0], 1'b0};
      if (north || south) begin
         push_entry.cls   = north ? CLS_NORTH : CLS_SOUTH;
         push_entry.att_y = pole_y;
         push_entry.att_x = pole_x;
      end else begin
         push_entry.cls   = CLS_GENERAL;
         push_entry.att_y = an;
         push_entry.att_x = ad;
      end
   end

   `QTE_ASSERT_NEXT(a_front_fill, clock, reset, req_valid && req_ready, f1_valid_ff)

endmodule

// ===== src/qte_queue.sv =====
`include "assert_macros.svh"

module qte_queue import qte_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  qte_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output qte_entry_type pop_entry
);

   qte_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         priority if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   `QTE_ASSERT_NEXT(a_queue_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1))
   `QTE_ASSERT_NEXT(a_queue_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - QCNT_W'(1))

endmodule

// ===== src/qte_cordic.sv =====
module qte_cordic import qte_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VEC_W-1:0] y_in,
   input  logic signed [VEC_W-1:0] x_in,
   output logic signed [ANG_W-1:0] angle
);

   logic signed [VEC_W-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [VEC_W-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0] z_ff [CORDIC_STAGES+1];
   logic                    zero_ff [CORDIC_STAGES+1];

   logic signed [VEC_W-1:0] pre_x_in, pre_y_in;
   logic signed [ANG_W-1:0] pre_z_in;

   // Fold the left half plane onto the right half, starting at plus or minus 180.
   always_comb begin
      pre_x_in = x_in;
      pre_y_in = y_in;
      pre_z_in = '0;
      if (x_in < 0) begin
         pre_x_in = -x_in;
         pre_y_in = -y_in;
         pre_z_in = (y_in < 0) ? -ANG_180 : ANG_180;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= pre_x_in;
         y_ff[0]    <= pre_y_in;
         z_ff[0]    <= pre_z_in;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   // One rotation toward the x axis per stage.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [VEC_W-1:0] dx, dy;
      logic signed [ANG_W-1:0] step;

      assign dx   = y_ff[i] >>> i;
      assign dy   = x_ff[i] >>> i;
      assign step = signed'({{(ANG_W-ATAN_W){1'b0}}, ATAN_TABLE[i]});

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] < 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end
         end
      end
   end

   // A zero vector has angle zero.
   assign angle = zero_ff[CORDIC_STAGES] ? '0 : z_ff[CORDIC_STAGES];

endmodule

// ===== src/qte_back.sv =====
`include "assert_macros.svh"

module qte_back import qte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  qte_entry_type      pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [13:0] rsp_bank_deg,
   output logic signed [14:0] rsp_heading_deg,
   output logic signed [15:0] rsp_attitude_deg
);

   localparam logic [RAD_W-1:0] ROOT_ONE = RAD_W'(1) << (2 * (ROOT_STEPS - 1));

   logic adv, pop;

   logic          vld_ff [OUT_LEVEL+1];
   qte_class_type cls_ff [OUT_LEVEL+1];

   logic signed [VEC_W-1:0] att_y_ff, att_x_ff, hd_y_ff, hd_x_ff;
   logic signed [S_W-1:0]   s0_ff, s1_ff, s2_ff;
   logic signed [RAD_W-1:0] ss_ff;
   logic [RAD_W-1:0]        rad_ff;

   logic [RAD_W-1:0]      sq_n_ff [ROOT_STEPS];
   logic [RAD_W-1:0]      sq_r_ff [ROOT_STEPS];
   logic signed [S_W-1:0] sq_s_ff [ROOT_STEPS];

   logic signed [ANG_W-1:0] att_ang, hd_ang, bank_ang;
   logic signed [ANG_W-1:0] att_dly_ff [ANG_DELAY];
   logic signed [ANG_W-1:0] hd_dly_ff [ANG_DELAY];
   logic signed [VEC_W-1:0] bank_y, bank_x;

   logic signed [FULL_W-1:0] bank_full, head_full, att_full, att_ext;
   logic signed [16:0]       bank_in, head_in, att_in;

   logic                     rsp_valid_ff;
   logic signed [13:0]       bank_ff;
   logic signed [14:0]       head_ff;
   logic signed [15:0]       att_ff;

   // Round half up to degrees times 64, then clamp to the symmetric limit.
   function automatic logic signed [16:0] round_sat(input logic signed [FULL_W-1:0] ang,
                                                    input logic [15:0] lim);
      logic signed [FULL_W:0] sum;
      logic signed [18:0]     v;
      logic signed [18:0]     l;
      sum = (FULL_W+1)'(ang) + (FULL_W+1)'(32768);
      v   = sum[FULL_W:16];
      l   = signed'({3'b000, lim});
      if (v > l) begin
         v = l;
      end
      if (v < -l) begin
         v = -l;
      end
      return v[16:0];
   endfunction

   // The whole back end advances together unless a finished word is held.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign pop       = pop_valid && adv;

   // Valid and class travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= OUT_LEVEL; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= pop;
         for (int k = 1; k <= OUT_LEVEL; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cls_ff[0] <= pop_entry.cls;
         for (int k = 1; k <= OUT_LEVEL; k++) begin
            cls_ff[k] <= cls_ff[k-1];
         end
      end
   end

   // Queue read register, square of the bank sine, and the root radicand.
   always_ff @(posedge clock) begin
      if (adv) begin
         att_y_ff <= pop_entry.att_y;
         att_x_ff <= pop_entry.att_x;
         hd_y_ff  <= pop_entry.hd_y;
         hd_x_ff  <= pop_entry.hd_x;
         s0_ff    <= pop_entry.s;
         ss_ff    <= RAD_W'(s0_ff) * RAD_W'(s0_ff);
         s1_ff    <= s0_ff;
         rad_ff   <= ROOT_ONE - $unsigned(ss_ff);
         s2_ff    <= s1_ff;
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [RAD_W-1:0] ROOT_BIT = RAD_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [RAD_W-1:0]      n_cur, r_cur, trial;
      logic signed [S_W-1:0] s_cur;

      if (k == 0) begin : g_first
         assign n_cur = rad_ff;
         assign r_cur = '0;
         assign s_cur = s2_ff;
      end else begin : g_next
         assign n_cur = sq_n_ff[k-1];
         assign r_cur = sq_r_ff[k-1];
         assign s_cur = sq_s_ff[k-1];
      end

      assign trial = r_cur + ROOT_BIT;

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_s_ff[k] <= s_cur;
            if (n_cur >= trial) begin
               sq_n_ff[k] <= n_cur - trial;
               sq_r_ff[k] <= (r_cur >> 1) + ROOT_BIT;
            end else begin
               sq_n_ff[k] <= n_cur;
               sq_r_ff[k] <= r_cur >> 1;
            end
         end
      end
   end

   // Angle units: attitude and heading start at once, bank after the root.
   qte_cordic u_att_cordic (
      .clock (clock),
      .en    (adv),
      .y_in  (att_y_ff),
      .x_in  (att_x_ff),
      .angle (att_ang)
   );

   qte_cordic u_hd_cordic (
      .clock (clock),
      .en    (adv),
      .y_in  (hd_y_ff),
      .x_in  (hd_x_ff),
      .angle (hd_ang)
   );

   assign bank_y = VEC_W'(sq_s_ff[ROOT_STEPS-1]);
   assign bank_x = {{(VEC_W-S_W){1'b0}}, sq_r_ff[ROOT_STEPS-1][S_W-1:0]};

   qte_cordic u_bank_cordic (
      .clock (clock),
      .en    (adv),
      .y_in  (bank_y),
      .x_in  (bank_x),
      .angle (bank_ang)
   );

   // Hold attitude and heading until the bank angle catches up.
   always_ff @(posedge clock) begin
      if (adv) begin
         att_dly_ff[0] <= att_ang;
         hd_dly_ff[0]  <= hd_ang;
         for (int j = 1; j < ANG_DELAY; j++) begin
            att_dly_ff[j] <= att_dly_ff[j-1];
            hd_dly_ff[j]  <= hd_dly_ff[j-1];
         end
      end
   end

   // Select the pole or general results and scale to the output format.
   always_comb begin
      att_ext = FULL_W'(att_dly_ff[ANG_DELAY-1]);
      unique case (cls_ff[OUT_LEVEL])
         CLS_NORTH: begin
            bank_full = ANG_90;
            head_full = '0;
            att_full  = att_ext <<< 1;
         end
         CLS_SOUTH: begin
            bank_full = -ANG_90;
            head_full = '0;
            att_full  = -(att_ext <<< 1);
         end
         default: begin
            bank_full = FULL_W'(bank_ang);
            head_full = FULL_W'(hd_dly_ff[ANG_DELAY-1]);
            att_full  = att_ext;
         end
      endcase
      bank_in = round_sat(bank_full, BANK_LIM);
      head_in = round_sat(head_full, HEAD_LIM);
      att_in  = round_sat(att_full, ATT_LIM);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[OUT_LEVEL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bank_ff <= bank_in[13:0];
         head_ff <= head_in[14:0];
         att_ff  <= att_in[15:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bank_deg     = bank_ff;
   assign rsp_heading_deg  = head_ff;
   assign rsp_attitude_deg = att_ff;

   `QTE_ASSERT_NEXT(a_back_load, clock, reset, adv && vld_ff[OUT_LEVEL], rsp_valid_ff)

endmodule

// ===== src/quaternion_to_euler_angles.sv =====
// Converts one unit orientation quaternion (w, x, y, z, signed Q1.14) per word into bank,
// heading and attitude angles in degrees times 64, with the pole cases resolved as bank
// plus or minus 90 and heading 0. A new word is taken every cycle unless the output side
// stalls. The longest path is the 29-stage square root that forms the bank cosine,
// followed by the bank angle unit; attitude and heading are resolved in parallel and
// held to line up. A four-word queue separates the product stage from the angle pipeline.
module quaternion_to_euler_angles import qte_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [IN_W-1:0] req_quat_w,
   input  logic signed [IN_W-1:0] req_quat_x,
   input  logic signed [IN_W-1:0] req_quat_y,
   input  logic signed [IN_W-1:0] req_quat_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [13:0]     rsp_bank_deg,
   output logic signed [14:0]     rsp_heading_deg,
   output logic signed [15:0]     rsp_attitude_deg
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   qte_entry_type push_entry, pop_entry;

   // Products and classification.
   qte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   qte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Square root, angle units and output register.
   qte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bank_deg     (rsp_bank_deg),
      .rsp_heading_deg  (rsp_heading_deg),
      .rsp_attitude_deg (rsp_attitude_deg)
   );

endmodule
